@@ rtl/core/mwlfo_pkg.sv @@
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared widths, register indexes, reset values, sine table and the stage
// payload type for the morphing wavetable LFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwlfo_pkg;

    localparam int ADC_W    = 10;
    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 11;
    localparam int LEVEL_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int TABLE_LEN = 128;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int WAVE_HALF = TABLE_LEN / 2;
    localparam int WAVE_LAST = TABLE_LEN - 2;
    localparam int STEP      = 2;

    localparam int BLEND_W     = 9;
    localparam int BLEND_FULL  = 512;
    localparam int BLEND_ROUND = 256;
    localparam int MIX_W       = 18;

    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = PERIOD_W'(600);
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = PERIOD_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = CFG_IDX_W'(1);

    localparam logic [LEVEL_W-1:0] SINE_ROM [TABLE_LEN] = '{
        8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
        8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
        8'd10,  8'd11,  8'd13,  8'd14,  8'd16,  8'd17,  8'd19,  8'd20,
        8'd22,  8'd24,  8'd26,  8'd27,  8'd29,  8'd31,  8'd34,  8'd36,
        8'd38,  8'd40,  8'd42,  8'd45,  8'd47,  8'd50,  8'd52,  8'd55,
        8'd57,  8'd60,  8'd62,  8'd65,  8'd68,  8'd71,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd116, 8'd119, 8'd122, 8'd125,
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd144, 8'd147, 8'd150,
        8'd153, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
        8'd177, 8'd180, 8'd183, 8'd185, 8'd188, 8'd191, 8'd194, 8'd196,
        8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd214, 8'd216,
        8'd218, 8'd220, 8'd222, 8'd225, 8'd227, 8'd229, 8'd230, 8'd232,
        8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
        8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
        8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    typedef struct packed {
        logic [IDX_W-1:0] table_index;
        logic [ADC_W-1:0] shape_adc;
    } t_wave_item;

endpackage

@@ rtl/core/mwlfo_tick.sv @@
// ----------------------------------------------------------------------------
// mwlfo_tick
// Tick stage: registers the incoming transaction, derives the tick period,
// runs the elapsed counter and the ping-pong table index, and hands fired
// steps to the blend stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwlfo_tick (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [mwlfo_pkg::ADC_W-1:0]        i_rate_adc,
    input  logic [mwlfo_pkg::ADC_W-1:0]        i_shape_adc,
    input  logic [mwlfo_pkg::PERIOD_W-1:0]     i_slow_period,
    input  logic [mwlfo_pkg::PERIOD_W-1:0]     i_fast_period,
    output logic                               o_fire_valid,
    input  logic                               i_fire_stall,
    output mwlfo_pkg::t_wave_item              o_item
);

    logic                              r_in_valid;
    logic [mwlfo_pkg::ADC_W-1:0]       r_rate_adc;
    logic [mwlfo_pkg::ADC_W-1:0]       r_shape_adc;
    logic [mwlfo_pkg::COUNT_W-1:0]     r_elapsed;
    logic [mwlfo_pkg::IDX_W-1:0]       r_table_index;
    logic                              r_rising;
    logic                              r_fire_valid;
    mwlfo_pkg::t_wave_item             r_item;

    logic [mwlfo_pkg::COUNT_W-1:0]     n_elapsed;
    logic [mwlfo_pkg::IDX_W-1:0]       n_table_index;
    logic                              n_rising;

    logic signed [mwlfo_pkg::PERIOD_W:0]       diff;
    logic signed [2*mwlfo_pkg::PERIOD_W+1:0]   prod;
    logic                                      trunc_adj;
    logic [mwlfo_pkg::PERIOD_W+1:0]            period_raw;
    logic [mwlfo_pkg::COUNT_W-1:0]             period;
    logic                                      fire;
    logic                                      fire_ready;
    logic                                      in_ready;
    logic                                      consume;

    always_comb begin
        diff = $signed({1'b0, i_fast_period}) - $signed({1'b0, i_slow_period});
        prod = $signed({1'b0, r_rate_adc}) * diff;
        trunc_adj = prod[2*mwlfo_pkg::PERIOD_W+1] && (prod[mwlfo_pkg::ADC_W-1:0] != '0);
        period_raw = {2'b00, i_slow_period}
                   + prod[2*mwlfo_pkg::PERIOD_W+1:mwlfo_pkg::ADC_W]
                   + {{(mwlfo_pkg::PERIOD_W+1){1'b0}}, trunc_adj};
        period = period_raw[mwlfo_pkg::PERIOD_W+1] ? '0
                                                   : period_raw[mwlfo_pkg::COUNT_W-1:0];
        n_elapsed = r_elapsed + mwlfo_pkg::COUNT_W'(1);
        fire = n_elapsed > period;
    end

    always_comb begin
        if (r_table_index >= mwlfo_pkg::IDX_W'(mwlfo_pkg::WAVE_LAST)) begin
            n_rising = 1'b0;
        end else if (r_table_index == '0) begin
            n_rising = 1'b1;
        end else begin
            n_rising = r_rising;
        end
        if (n_rising) begin
            n_table_index = r_table_index + mwlfo_pkg::IDX_W'(mwlfo_pkg::STEP);
        end else begin
            n_table_index = r_table_index - mwlfo_pkg::IDX_W'(mwlfo_pkg::STEP);
        end
    end

    assign fire_ready = !r_fire_valid || !i_fire_stall;
    assign in_ready   = !r_in_valid || fire_ready;
    assign consume    = r_in_valid && fire_ready;
    assign o_stall    = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_elapsed     <= '0;
            r_table_index <= '0;
            r_rising      <= 1'b1;
            r_fire_valid  <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (consume) begin
                r_elapsed <= fire ? '0 : n_elapsed;
                if (fire) begin
                    r_table_index <= n_table_index;
                    r_rising      <= n_rising;
                end
            end
            if (fire_ready) begin
                r_fire_valid <= consume && fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_rate_adc  <= i_rate_adc;
            r_shape_adc <= i_shape_adc;
        end
        if (consume && fire) begin
            r_item.table_index <= n_table_index;
            r_item.shape_adc   <= r_shape_adc;
        end
    end

    assign o_fire_valid = r_fire_valid;
    assign o_item       = r_item;

    a_index_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_table_index[0] == 1'b0)
        else $error("table index left the even grid");

    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed <= mwlfo_pkg::COUNT_W'(1024))
        else $error("elapsed count ran past the longest period");

    a_fire_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fire_valid) |-> $past(r_in_valid))
        else $error("step fired without a registered transaction");

endmodule

@@ rtl/core/mwlfo_blend.sv @@
// ----------------------------------------------------------------------------
// mwlfo_blend
// Blend stage: looks up triangle, sine and square at the table position and
// crossfades the selected pair by the shape reading into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwlfo_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  mwlfo_pkg::t_wave_item          i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mwlfo_pkg::LEVEL_W-1:0]  o_level
);

    logic                              r_valid;
    logic [mwlfo_pkg::LEVEL_W-1:0]     r_level;

    logic [mwlfo_pkg::IDX_W-1:0]       pos;
    logic [mwlfo_pkg::LEVEL_W-1:0]     sine;
    logic [mwlfo_pkg::LEVEL_W-1:0]     tri_wave;
    logic [mwlfo_pkg::LEVEL_W-1:0]     sq_wave;
    logic [mwlfo_pkg::LEVEL_W-1:0]     wave_a;
    logic [mwlfo_pkg::LEVEL_W-1:0]     wave_b;
    logic [mwlfo_pkg::BLEND_W-1:0]     weight;
    logic [mwlfo_pkg::BLEND_W:0]       weight_inv;
    logic [mwlfo_pkg::MIX_W-1:0]       mix;
    logic [mwlfo_pkg::LEVEL_W-1:0]     n_level;
    logic                              ready;

    always_comb begin
        pos      = i_item.table_index;
        sine     = mwlfo_pkg::SINE_ROM[pos];
        tri_wave = (pos <= mwlfo_pkg::IDX_W'(mwlfo_pkg::WAVE_HALF))
                 ? {pos, 1'b0}
                 : {pos, 1'b0} - mwlfo_pkg::LEVEL_W'(1);
        sq_wave  = (pos < mwlfo_pkg::IDX_W'(mwlfo_pkg::WAVE_HALF)) ? '0 : '1;
        weight   = i_item.shape_adc[mwlfo_pkg::BLEND_W-1:0];
        if (i_item.shape_adc[mwlfo_pkg::BLEND_W]) begin
            wave_a = sq_wave;
            wave_b = sine;
        end else begin
            wave_a = sine;
            wave_b = tri_wave;
        end
        weight_inv = (mwlfo_pkg::BLEND_W+1)'(mwlfo_pkg::BLEND_FULL) - {1'b0, weight};
        mix = mwlfo_pkg::MIX_W'(weight) * mwlfo_pkg::MIX_W'(wave_a)
            + mwlfo_pkg::MIX_W'(weight_inv) * mwlfo_pkg::MIX_W'(wave_b)
            + mwlfo_pkg::MIX_W'(mwlfo_pkg::BLEND_ROUND);
        n_level = mix[mwlfo_pkg::BLEND_W +: mwlfo_pkg::LEVEL_W];
    end

    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && ready) begin
            r_level <= n_level;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(i_valid))
        else $error("level appeared without a fired step");

endmodule

@@ rtl/core/morphing_wavetable_lfo_unit.sv @@
// ----------------------------------------------------------------------------
// morphing_wavetable_lfo_unit
// Tremolo LFO: one transaction per millisecond tick, a level out each time the
// elapsed count passes the rate-dependent period.
// Path: a firing tick transaction is registered by the input, tick and blend
// stages in turn before o_valid rises; a stall can hold it in any of them.
// Throughput: one tick transaction per cycle unless stalled; three registered
// stages (input, tick, blend) each hold one, moving on when the next is free.
// Reset: synchronous, active low; period registers return to 600 and 1, the
// counter and table index clear, the index heads upward, all stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morphing_wavetable_lfo_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mwlfo_pkg::ADC_W-1:0]       i_rate_adc,
    input  logic [mwlfo_pkg::ADC_W-1:0]       i_shape_adc,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mwlfo_pkg::LEVEL_W-1:0]     o_level,
    input  logic                              i_cfg_we,
    input  logic [mwlfo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mwlfo_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [mwlfo_pkg::PERIOD_W-1:0]  r_slow_period;
    logic [mwlfo_pkg::PERIOD_W-1:0]  r_fast_period;

    logic                            fire_valid;
    logic                            fire_stall;
    mwlfo_pkg::t_wave_item           fire_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period <= mwlfo_pkg::SLOW_PERIOD_RST;
            r_fast_period <= mwlfo_pkg::FAST_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mwlfo_pkg::CFG_SLOW_PERIOD: begin
                    r_slow_period <= i_cfg_data[mwlfo_pkg::PERIOD_W-1:0];
                end
                mwlfo_pkg::CFG_FAST_PERIOD: begin
                    r_fast_period <= i_cfg_data[mwlfo_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mwlfo_tick u_tick (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rate_adc    (i_rate_adc),
        .i_shape_adc   (i_shape_adc),
        .i_slow_period (r_slow_period),
        .i_fast_period (r_fast_period),
        .o_fire_valid  (fire_valid),
        .i_fire_stall  (fire_stall),
        .o_item        (fire_item)
    );

    mwlfo_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire_valid),
        .o_stall (fire_stall),
        .i_item  (fire_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_level (o_level)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output side was free");

endmodule
